[hw/rtl/aec_pkg.sv]
// Shared types and helpers for the animation channel evaluator.
// Holds the channel and result transaction structs, curve kind codes and
// the 32-bit saturation function. No dependencies.
`default_nettype none

package aec_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Highest param code that names a pose field (rotation, position, scale).
  localparam logic [3:0] PARAM_LAST_POSE = 4'd8;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_LINEAR = 2'd1,
    KIND_CUBIC  = 2'd2,
    KIND_STEP   = 2'd3
  } kind_e;

  typedef struct packed {
    logic               first_of_object;
    logic [1:0]         kind;
    logic [3:0]         param;
    logic signed [31:0] time_before;
    logic signed [31:0] speed;
    logic               advance;
    logic               skip_eval;
    logic signed [31:0] initial_value;
    logic signed [31:0] target_value;
    logic signed [31:0] start_rate;
    logic signed [31:0] end_rate;
    logic signed [31:0] key_param;
  } chan_t;

  typedef struct packed {
    logic               group_start;
    logic signed [31:0] new_time;
    logic signed [31:0] value;
    logic               value_valid;
    logic [3:0]         param_out;
    logic               step_crossed;
  } res_t;

  // Per-channel context that travels down the pipeline with each item.
  typedef struct packed {
    logic               first;
    logic [1:0]         kind;
    logic [3:0]         param;
    logic               skip;
    logic               crossed;
    logic               step_hi;
    logic signed [31:0] t;
    logic signed [31:0] iv;
    logic signed [31:0] tv;
    logic signed [31:0] r0;
    logic signed [31:0] r1;
  } ctx_t;

  localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
  localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) begin
      r = 32'sh7fff_ffff;
    end else if (v < SAT_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/anim_channel_evaluator.sv]
// Animation channel evaluator: time advance and linear, cubic Hermite or
// step evaluation of one channel per transaction, signed fixed point.
// Depends on aec_pkg for the transaction structs, kind codes and sat32.
//
// Usage:
//   Channel transactions enter on chan / chan_valid / chan_stall; results
//   leave on res / res_valid / res_stall. A transaction is taken at a rising
//   edge where valid is high and stall is low.
//   Throughput is one channel per cycle while res_stall is low: the
//   evaluator is a nine-stage pipeline in which the cubic path is the
//   longest chain (time scale, square, cube, Hermite basis, four weighted
//   products and their sum), one multiplier deep per stage.
//   Each stage holds only while the stage after it is full and stalled, so
//   empty stages close up behind a stalled result and chan_stall rises only
//   when all nine stages are occupied and res_stall is high. A held result
//   does not change.
//   Synchronous reset empties the pipeline; there are no configuration
//   registers and no stored state between channels. The per-object crossing
//   flag is the OR of step_crossed over the results that follow a
//   group_start, formed by the consumer.
`default_nettype none

module anim_channel_evaluator #(
  parameter int FRAC_BITS = aec_pkg::FRAC_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire aec_pkg::chan_t chan,
  input  wire logic           chan_valid,
  output      logic           chan_stall,
  output      aec_pkg::res_t  res,
  output      logic           res_valid,
  input  wire logic           res_stall
);
  import aec_pkg::*;

  localparam int NST = 9;
  localparam logic signed [63:0] RND = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  function automatic logic signed [63:0] qmul(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return (p + RND) >>> FRAC_BITS;
  endfunction

  logic [NST:1] vld;
  logic [NST:1] en;

  // A stage may load when it is empty or the stage after it moves on.
  always_comb begin
    en[NST] = !vld[NST] || !res_stall;
    for (int k = NST - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k + 1];
    end
  end

  assign chan_stall = !en[1];
  assign res_valid  = vld[NST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= chan_valid;
      end
      for (int k = 2; k <= NST; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k - 1];
        end
      end
    end
  end

  // Stage 1: advance time with saturation.
  ctx_t               c1;
  logic signed [31:0] tb1, kp1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      c1.first   <= chan.first_of_object;
      c1.kind    <= chan.kind;
      c1.param   <= chan.param;
      c1.skip    <= chan.skip_eval;
      c1.crossed <= 1'b0;
      c1.step_hi <= 1'b0;
      if (chan.kind != KIND_NONE && chan.advance) begin
        c1.t <= sat32(66'($signed(chan.time_before)) + 66'($signed(chan.speed)));
      end else begin
        c1.t <= chan.time_before;
      end
      c1.iv <= chan.initial_value;
      c1.tv <= chan.target_value;
      c1.r0 <= chan.start_rate;
      c1.r1 <= chan.end_rate;
      tb1   <= chan.time_before;
      kp1   <= chan.key_param;
    end
  end

  // Stage 2: scaled time s, linear product, step decisions.
  ctx_t               c2, c2_next;
  logic signed [31:0] s2r;
  logic signed [63:0] linp2;

  always_comb begin
    c2_next         = c1;
    c2_next.step_hi = kp1 <= $signed(c1.t);
    c2_next.crossed = c1.kind == KIND_STEP && c1.iv != c1.tv && tb1 < kp1 &&
                      kp1 <= $signed(c1.t) && c1.param <= PARAM_LAST_POSE;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c2    <= c2_next;
      s2r   <= sat32(66'(qmul(c1.t, kp1)));
      linp2 <= qmul(c1.t, c1.r0);
    end
  end

  // Stage 3: s squared, linear value.
  ctx_t               c3;
  logic signed [31:0] s3r, sq3, lin3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      c3   <= c2;
      s3r  <= s2r;
      sq3  <= sat32(66'(qmul(s2r, s2r)));
      lin3 <= sat32(66'($signed(c2.iv)) + 66'(linp2));
    end
  end

  // Stage 4: s cubed and the two tangent basis arguments.
  ctx_t               c4;
  logic signed [31:0] lin4, sq4, cu4, w1_4, w2_4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      c4   <= c3;
      lin4 <= lin3;
      sq4  <= sq3;
      cu4  <= sat32(66'(qmul(sq3, s3r)));
      w1_4 <= sat32(66'(sq3) - (66'(s3r) <<< 1) + 66'(ONE));
      w2_4 <= sat32(66'(sq3) - 66'(s3r));
    end
  end

  // Stage 5: 2s^3 - 3s^2 and the tangent basis values.
  ctx_t               c5;
  logic signed [31:0] lin5, a5, u5, v5;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      c5   <= c4;
      lin5 <= lin4;
      a5   <= sat32((66'(cu4) <<< 1) - (66'(sq4) + (66'(sq4) <<< 1)));
      u5   <= sat32(66'(qmul(c4.t, w1_4)));
      v5   <= sat32(66'(qmul(c4.t, w2_4)));
    end
  end

  // Stage 6: endpoint basis values.
  ctx_t               c6;
  logic signed [31:0] lin6, h0_6, h1_6, u6, v6;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      c6   <= c5;
      lin6 <= lin5;
      h0_6 <= sat32(66'(a5) + 66'(ONE));
      h1_6 <= sat32(-66'(a5));
      u6   <= u5;
      v6   <= v5;
    end
  end

  // Stage 7: the four weighted terms.
  ctx_t               c7;
  logic signed [31:0] lin7;
  logic signed [63:0] p0_7, p1_7, p2_7, p3_7;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      c7   <= c6;
      lin7 <= lin6;
      p0_7 <= qmul(c6.iv, h0_6);
      p1_7 <= qmul(c6.tv, h1_6);
      p2_7 <= qmul(c6.r0, u6);
      p3_7 <= qmul(c6.r1, v6);
    end
  end

  // Stage 8: pairwise sums.
  ctx_t               c8;
  logic signed [31:0] lin8;
  logic signed [65:0] q0_8, q1_8;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      c8   <= c7;
      lin8 <= lin7;
      q0_8 <= 66'(p0_7) + 66'(p1_7);
      q1_8 <= 66'(p2_7) + 66'(p3_7);
    end
  end

  // Stage 9: value selection into the output register.
  logic signed [31:0] value_sel;

  always_comb begin
    unique case (c8.kind)
      KIND_LINEAR: value_sel = lin8;
      KIND_CUBIC:  value_sel = sat32(q0_8 + q1_8);
      KIND_STEP:   value_sel = c8.step_hi ? c8.tv : c8.iv;
      default:     value_sel = '0;
    endcase
    if (c8.skip) begin
      value_sel = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      res.group_start  <= c8.first;
      res.new_time     <= c8.t;
      res.value        <= value_sel;
      res.value_valid  <= c8.kind != KIND_NONE && !c8.skip &&
                          c8.param <= PARAM_LAST_POSE;
      res.param_out    <= c8.param;
      res.step_crossed <= c8.crossed;
    end
  end

  // The input side only stalls when every stage holds an item and the
  // output is blocked.
  assert property (@(posedge clk) disable iff (rst)
    chan_stall |-> (&vld) && res_stall)
    else $error("input stalled while the pipeline had room");

  // A step crossing can only be reported for a pose parameter.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.step_crossed |-> res.param_out <= PARAM_LAST_POSE)
    else $error("step crossing reported for a non-pose parameter");

  // Skipped or unused channels produce a zero value and no write.
  assert property (@(posedge clk) disable iff (rst)
    vld[8] && en[9] && (c8.skip || c8.kind == KIND_NONE)
      |=> res.value == '0 && !res.value_valid)
    else $error("suppressed channel produced a value");

endmodule

`default_nettype wire
